// ----- src/ffa_pkg.sv -----
package ffa_pkg;

    // Configuration register
    localparam int          CFG_W      = 13;
    localparam logic [12:0] GROW_RESET = 13'd1024;

    // Result unit field width
    localparam int UNIT_OUT_W = 12;

    // Request actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_OOM = 1'b1;

    typedef struct packed {
        logic        action;
        logic [15:0] item_count;
        logic [15:0] item_bytes;
        logic [11:0] release_unit;
    } req_t;

    typedef struct packed {
        logic        status;
        logic [11:0] block_unit;
    } rsp_t;

    // Datapath commands, one per cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_MUL,
        OP_DIV,
        OP_NU,
        OP_A_START,
        OP_A_PREV,
        OP_A_RD,
        OP_A_TAKE,
        OP_A_CUT,
        OP_A_SPLIT,
        OP_A_GROW,
        OP_A_NEXT,
        OP_FAIL,
        OP_R_INIT,
        OP_R_RD,
        OP_R_NEXT,
        OP_R_HIT,
        OP_R_RDQ,
        OP_R_WBP,
        OP_R_WP,
        OP_OUT
    } op_t;

    // Datapath status toward the controller
    typedef struct packed {
        logic is_free;
        logic free_ok;
        logic div_busy;
        logic a_over;
        logic fit;
        logic exact;
        logic at_cursor;
        logic grow_ok;
        logic r_over;
        logic found;
        logic out_free;
    } stat_t;

endpackage

// ----- src/ffa_div.sv -----
module ffa_div #(
    parameter int DIVISOR = 16,
    parameter int DW      = 33,
    parameter int LIMIT   = 65536
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    output logic [DW-1:0] quotient,
    output logic          busy
);
    // Reciprocal constants, exact for every dividend below 2**XW
    localparam int              XW  = $clog2(LIMIT);
    localparam int              LW  = $clog2(DIVISOR);
    localparam int              SH  = XW + LW;
    localparam int              MW  = XW + 1;
    localparam int              PW  = XW + MW;
    localparam longint unsigned RCP = ((64'd1 << SH) + 64'(DIVISOR - 1)) / 64'(DIVISOR);

    logic [XW-1:0] x_reg;
    logic          big_reg;
    logic [DW-1:0] quo_reg;
    logic          busy_reg;
    logic [PW-1:0] prod;

    // Scale by the reciprocal; the top bits are the quotient
    assign prod = PW'(x_reg) * PW'(MW'(RCP));

    // Hold busy for the one multiply cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
        end
    end

    // Capture the dividend, flag anything past the arena, then load the quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= dividend[XW-1:0];
            big_reg <= dividend >= DW'(LIMIT);
        end
        if (busy_reg)
        begin
            quo_reg <= big_reg ? DW'(LIMIT / DIVISOR) : DW'(prod[PW-1:SH]);
        end
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;

endmodule

// ----- src/ffa_dpath.sv -----
module ffa_dpath #(
    parameter int HEAP_UNITS = 4096,
    parameter int UNIT_BYTES = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ffa_pkg::op_t             op,
    output ffa_pkg::stat_t           stat,
    input  ffa_pkg::req_t            req,
    input  logic                     cfg_we,
    input  logic [ffa_pkg::CFG_W-1:0] cfg_data,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output ffa_pkg::rsp_t            rsp
);
    import ffa_pkg::*;

    localparam int AW   = $clog2(HEAP_UNITS);
    localparam int BW   = AW + 1;
    localparam int NUW  = AW + 1;
    localparam int GW   = ((NUW > CFG_W) ? NUW : CFG_W) + 1;
    localparam int RLW  = (BW > 13) ? BW : 13;
    localparam int ALIM = 3 * HEAP_UNITS + 8;
    localparam int ASW  = $clog2(ALIM + 1);
    localparam int RSW  = $clog2(HEAP_UNITS + 2);
    localparam int DW   = 33;

    // Header store: {next link, size}
    logic [2*AW-1:0] hdr_mem [HEAP_UNITS];
    logic [2*AW-1:0] rd_raw_reg;
    logic            rd_zero_reg;
    logic            hdr0_valid_reg;

    req_t                  req_reg;
    logic [31:0]           prod_reg;
    logic [NUW-1:0]        nu_reg;
    logic [CFG_W-1:0]      mg_reg;
    logic [AW-1:0]         cursor_reg;
    logic [BW-1:0]         break_reg;
    logic [AW-1:0]         prev_reg;
    logic [AW-1:0]         prev_size_reg;
    logic [AW-1:0]         p_reg;
    logic [AW-1:0]         q_reg;
    logic [AW-1:0]         sp_reg;
    logic [AW-1:0]         sbp_reg;
    logic [AW-1:0]         nbl_reg;
    logic [AW-1:0]         nbs_reg;
    logic [AW-1:0]         bp_reg;
    logic [ASW-1:0]        astep_reg;
    logic [RSW-1:0]        rstep_reg;
    logic                  status_reg;
    logic [UNIT_OUT_W-1:0] unit_reg;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;

    logic [AW-1:0]   rlink;
    logic [AW-1:0]   rsize;
    logic [AW-1:0]   cut_size;
    logic [GW-1:0]   ng;
    logic            grow_ok;
    logic            found;
    logic            merge_next;
    logic            merge_prev;
    logic [AW-1:0]   nbl_c;
    logic [AW-1:0]   nbs_c;
    logic [RLW-1:0]  rel_m1;
    logic            free_ok;
    logic [DW-1:0]   dividend;
    logic [DW-1:0]   quot;
    logic            div_busy;
    logic [NUW-1:0]  nu_c;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [2*AW-1:0] mem_wd;
    logic [AW-1:0]   mem_ra;

    // Unit count divider
    assign dividend = {1'b0, prod_reg} + DW'(UNIT_BYTES - 1);

    ffa_div #(
        .DIVISOR (UNIT_BYTES),
        .DW      (DW),
        .LIMIT   (HEAP_UNITS * UNIT_BYTES)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (op == OP_DIV),
        .dividend (dividend),
        .quotient (quot),
        .busy     (div_busy)
    );

    // Clamp: anything past the arena can never fit
    assign nu_c = (quot >= DW'(HEAP_UNITS)) ? NUW'(HEAP_UNITS + 1)
                                            : NUW'(quot) + NUW'(1);

    // Read data; the sentinel reads as zero until first written
    assign rlink = rd_zero_reg ? '0 : rd_raw_reg[2*AW-1:AW];
    assign rsize = rd_zero_reg ? '0 : rd_raw_reg[AW-1:0];

    // Allocation checks
    assign cut_size = rsize - nu_reg[AW-1:0];
    assign ng       = (GW'(nu_reg) > GW'(mg_reg)) ? GW'(nu_reg) : GW'(mg_reg);
    assign grow_ok  = (GW'(break_reg) + ng) <= GW'(HEAP_UNITS);

    // Release placement and merge checks
    assign found = (bp_reg > p_reg && bp_reg < rlink)
                || (p_reg >= rlink && (bp_reg > p_reg || bp_reg < rlink));
    assign merge_next = (BW'(bp_reg) + BW'(sbp_reg)) == BW'(q_reg);
    assign merge_prev = (BW'(p_reg) + BW'(sp_reg)) == BW'(bp_reg);
    assign nbl_c      = merge_next ? rlink : q_reg;
    assign nbs_c      = merge_next ? (sbp_reg + rsize) : sbp_reg;

    // Free range check
    assign rel_m1  = RLW'(req_reg.release_unit) - RLW'(1);
    assign free_ok = (req_reg.release_unit >= 12'd2) && (rel_m1 < RLW'(break_reg));

    // Status toward the controller
    always_comb
    begin
        stat.is_free   = req_reg.action == ACT_FREE;
        stat.free_ok   = free_ok;
        stat.div_busy  = div_busy;
        stat.a_over    = astep_reg >= ASW'(ALIM);
        stat.fit       = {1'b0, rsize} >= nu_reg;
        stat.exact     = {1'b0, rsize} == nu_reg;
        stat.at_cursor = p_reg == cursor_reg;
        stat.grow_ok   = grow_ok;
        stat.r_over    = rstep_reg > RSW'(HEAP_UNITS);
        stat.found     = found;
        stat.out_free  = !rsp_valid_reg || !rsp_stall;
    end

    // Header store port select
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        mem_ra = '0;
        case (op)
            OP_A_START: mem_ra = cursor_reg;
            OP_A_RD:    mem_ra = p_reg;
            OP_R_RD:    mem_ra = p_reg;
            OP_R_HIT:   mem_ra = bp_reg;
            OP_R_RDQ:   mem_ra = q_reg;
            OP_A_TAKE:
            begin
                mem_we = 1'b1;
                mem_wa = prev_reg;
                mem_wd = {rlink, prev_size_reg};
            end
            OP_A_CUT:
            begin
                mem_we = 1'b1;
                mem_wa = p_reg;
                mem_wd = {rlink, cut_size};
            end
            OP_A_SPLIT:
            begin
                mem_we = 1'b1;
                mem_wa = q_reg;
                mem_wd = {{AW{1'b0}}, nu_reg[AW-1:0]};
            end
            OP_A_GROW:
            begin
                mem_we = 1'b1;
                mem_wa = break_reg[AW-1:0];
                mem_wd = {{AW{1'b0}}, ng[AW-1:0]};
            end
            OP_R_WBP:
            begin
                mem_we = 1'b1;
                mem_wa = bp_reg;
                mem_wd = {nbl_c, nbs_c};
            end
            OP_R_WP:
            begin
                mem_we = 1'b1;
                mem_wa = p_reg;
                mem_wd = merge_prev ? {nbl_reg, sp_reg + nbs_reg} : {bp_reg, sp_reg};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Header store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hdr_mem[mem_wa] <= mem_wd;
        end
        rd_raw_reg <= hdr_mem[mem_ra];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr0_valid_reg <= 1'b0;
            rd_zero_reg    <= 1'b0;
            mg_reg         <= GROW_RESET;
            cursor_reg     <= '0;
            break_reg      <= BW'(1);
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (mem_we && mem_wa == '0)
            begin
                hdr0_valid_reg <= 1'b1;
            end
            rd_zero_reg <= (mem_ra == '0) && !hdr0_valid_reg;
            if (cfg_we)
            begin
                mg_reg <= cfg_data;
            end
            if (op == OP_A_TAKE || op == OP_A_CUT)
            begin
                cursor_reg <= prev_reg;
            end
            else if (op == OP_R_WP)
            begin
                cursor_reg <= p_reg;
            end
            if (op == OP_A_GROW)
            begin
                break_reg <= break_reg + BW'(ng);
            end
            if (op == OP_OUT)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LATCH:
            begin
                req_reg    <= req;
                astep_reg  <= '0;
                status_reg <= ST_OK;
                unit_reg   <= '0;
            end
            OP_MUL:
            begin
                prod_reg <= 32'(req_reg.item_count) * 32'(req_reg.item_bytes);
                bp_reg   <= rel_m1[AW-1:0];
            end
            OP_NU:      nu_reg <= nu_c;
            OP_A_PREV:
            begin
                prev_reg      <= cursor_reg;
                prev_size_reg <= rsize;
                p_reg         <= rlink;
            end
            OP_A_RD:    astep_reg <= astep_reg + ASW'(1);
            OP_A_NEXT:
            begin
                prev_reg      <= p_reg;
                prev_size_reg <= rsize;
                p_reg         <= rlink;
            end
            OP_A_TAKE:
            begin
                status_reg <= ST_OK;
                unit_reg   <= UNIT_OUT_W'({1'b0, p_reg} + BW'(1));
            end
            OP_A_CUT:   q_reg <= p_reg + cut_size;
            OP_A_SPLIT:
            begin
                status_reg <= ST_OK;
                unit_reg   <= UNIT_OUT_W'({1'b0, q_reg} + BW'(1));
            end
            OP_A_GROW:  bp_reg <= break_reg[AW-1:0];
            OP_FAIL:
            begin
                status_reg <= ST_OOM;
                unit_reg   <= '0;
            end
            OP_R_INIT:
            begin
                p_reg     <= cursor_reg;
                rstep_reg <= '0;
            end
            OP_R_RD:    rstep_reg <= rstep_reg + RSW'(1);
            OP_R_NEXT:  p_reg <= rlink;
            OP_R_HIT:
            begin
                q_reg  <= rlink;
                sp_reg <= rsize;
            end
            OP_R_RDQ:   sbp_reg <= rsize;
            OP_R_WBP:
            begin
                nbl_reg <= nbl_c;
                nbs_reg <= nbs_c;
            end
            OP_OUT:
            begin
                rsp_reg.status     <= status_reg;
                rsp_reg.block_unit <= unit_reg;
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The arena never grows past its end
    a_break_bound: assert property (@(posedge clk) disable iff (!rst_n)
        break_reg <= BW'(HEAP_UNITS))
        else $error("break pointer past arena end");

    // The break pointer moves only on a growth step
    a_break_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (op != OP_A_GROW) |=> $stable(break_reg))
        else $error("break pointer moved outside growth");

    // Growth is commanded only when it fits
    a_grow_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_A_GROW) |-> grow_ok)
        else $error("growth commanded past arena end");

    // A result appears only on an output load
    a_rsp_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(op == OP_OUT))
        else $error("result valid without load");

endmodule

// ----- src/ffa_ctrl.sv -----
module ffa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ffa_pkg::stat_t stat,
    output ffa_pkg::op_t   op
);
    import ffa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_DIVW,
        S_A_START,
        S_A_PREV,
        S_A_RD,
        S_A_EVAL,
        S_A_SPLIT,
        S_R_INIT,
        S_R_RD,
        S_R_EVAL,
        S_R_RDQ,
        S_R_WBP,
        S_R_WP,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   grow_reg;
    logic   grow_next;
    logic   stall_reg;

    // Sequence the request
    always_comb
    begin
        state_next = state_reg;
        grow_next  = grow_reg;
        op         = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op         = OP_LATCH;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                op        = OP_MUL;
                grow_next = 1'b0;
                if (!stat.is_free)
                begin
                    state_next = S_DIV;
                end
                else if (stat.free_ok)
                begin
                    state_next = S_R_INIT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                op         = OP_DIV;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (!stat.div_busy)
                begin
                    op         = OP_NU;
                    state_next = S_A_START;
                end
            end
            S_A_START:
            begin
                op         = OP_A_START;
                state_next = S_A_PREV;
            end
            S_A_PREV:
            begin
                op         = OP_A_PREV;
                state_next = S_A_RD;
            end
            S_A_RD:
            begin
                if (stat.a_over)
                begin
                    op         = OP_FAIL;
                    state_next = S_DONE;
                end
                else
                begin
                    op         = OP_A_RD;
                    state_next = S_A_EVAL;
                end
            end
            S_A_EVAL:
            begin
                if (stat.fit)
                begin
                    if (stat.exact)
                    begin
                        op         = OP_A_TAKE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        op         = OP_A_CUT;
                        state_next = S_A_SPLIT;
                    end
                end
                else if (stat.at_cursor)
                begin
                    if (stat.grow_ok)
                    begin
                        op         = OP_A_GROW;
                        grow_next  = 1'b1;
                        state_next = S_R_INIT;
                    end
                    else
                    begin
                        op         = OP_FAIL;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    op         = OP_A_NEXT;
                    state_next = S_A_RD;
                end
            end
            S_A_SPLIT:
            begin
                op         = OP_A_SPLIT;
                state_next = S_DONE;
            end
            S_R_INIT:
            begin
                op         = OP_R_INIT;
                state_next = S_R_RD;
            end
            S_R_RD:
            begin
                if (stat.r_over)
                begin
                    state_next = grow_reg ? S_A_START : S_DONE;
                end
                else
                begin
                    op         = OP_R_RD;
                    state_next = S_R_EVAL;
                end
            end
            S_R_EVAL:
            begin
                if (stat.found)
                begin
                    op         = OP_R_HIT;
                    state_next = S_R_RDQ;
                end
                else
                begin
                    op         = OP_R_NEXT;
                    state_next = S_R_RD;
                end
            end
            S_R_RDQ:
            begin
                op         = OP_R_RDQ;
                state_next = S_R_WBP;
            end
            S_R_WBP:
            begin
                op         = OP_R_WBP;
                state_next = S_R_WP;
            end
            S_R_WP:
            begin
                op         = OP_R_WP;
                state_next = grow_reg ? S_A_START : S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    op         = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the registered stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            grow_reg  <= 1'b0;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            grow_reg  <= grow_next;
            stall_reg <= state_next != S_IDLE;
        end
    end

    assign req_stall = stall_reg;

endmodule

// ----- src/first_fit_free_list_allocator.sv -----
// Sequence: a free walks the free blocks it passes and then writes its headers; an ignored free
//   goes straight to its result; an allocate first does the size calculation (multiply,
//   reciprocal multiply), then visits blocks on the single-port header memory, one more write
//   for a split, plus a full release walk for each arena growth.
// Throughput: one request at a time; a finished result may wait in the output register.
// Reset: cursor to the sentinel, break pointer 1, growth minimum 1024; memory is not cleared.
module first_fit_free_list_allocator #(
    parameter int HEAP_UNITS = 4096,
    parameter int UNIT_BYTES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  ffa_pkg::req_t             req,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output ffa_pkg::rsp_t             rsp,
    input  logic                      cfg_we,
    input  logic [ffa_pkg::CFG_W-1:0] cfg_data
);
    import ffa_pkg::*;

    op_t   op;
    stat_t stat;

    // Sequencer
    ffa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .op        (op)
    );

    // Header memory and arithmetic
    ffa_dpath #(
        .HEAP_UNITS (HEAP_UNITS),
        .UNIT_BYTES (UNIT_BYTES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .stat      (stat),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ----- dv/tb_first_fit_free_list_allocator.sv -----
module tb_first_fit_free_list_allocator;
    import ffa_pkg::*;

    localparam int HEAP = 4096;
    localparam int UNIT_B = 16;
    localparam int STALL_LIMIT = 40000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS = 250;

    // Free-pick modes for directed rows
    localparam int PICK_NONE = 0;
    localparam int PICK_NEWEST = 1;
    localparam int PICK_OLDEST = 2;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;
    logic cfg_we;
    logic [CFG_W-1:0] cfg_data;

    first_fit_free_list_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // Shadow allocator state
    int unsigned hdr_next [HEAP];
    int unsigned hdr_size [HEAP];
    int unsigned rover;
    int unsigned brk;
    int unsigned grow_min;

    rsp_t pending_rsp[$];
    int unsigned live_blocks[$];

    int mismatches;
    int idle_cycles;
    bit quiet_rsp;
    bit quiet_req;
    int stall_hold;
    int n_alloc, n_oom, n_free, n_cfg, n_rsp;

    typedef struct {
        logic        action;
        logic [15:0] count;
        logic [15:0] bytes;
        logic [11:0] rel;
        int          pick;
        bit          typed;
        logic        st;
        logic [11:0] unit;
    } dir_row_t;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int unsigned link_of(int unsigned i);
        return i < HEAP ? hdr_next[i] : 0;
    endfunction

    function automatic int unsigned size_of(int unsigned i);
        return i < HEAP ? hdr_size[i] : 0;
    endfunction

    function automatic void set_link(int unsigned i, int unsigned v);
        if (i < HEAP) hdr_next[i] = v;
    endfunction

    function automatic void set_size(int unsigned i, int unsigned v);
        if (i < HEAP) hdr_size[i] = v;
    endfunction

    // Insert a block in address order and merge with both neighbors
    function automatic bit put_back(int unsigned bp);
        int unsigned p;
        int unsigned q;
        int unsigned steps;
        p = rover;
        steps = 0;
        forever
        begin
            if (steps > HEAP) return 1'b0;
            steps++;
            q = link_of(p);
            if (bp > p && bp < q) break;
            if (p >= q && (bp > p || bp < q)) break;
            p = q;
        end
        if (bp + size_of(bp) == q)
        begin
            set_size(bp, size_of(bp) + size_of(q));
            set_link(bp, link_of(q));
        end
        else
            set_link(bp, q);
        if (p + size_of(p) == bp)
        begin
            set_link(p, link_of(bp));
            set_size(p, size_of(p) + size_of(bp));
        end
        else
            set_link(p, bp);
        rover = p;
        return 1'b1;
    endfunction

    function automatic bit extend_arena(longint unsigned need);
        longint unsigned nu;
        int unsigned up;
        bit dummy;
        nu = need;
        if (nu < grow_min) nu = grow_min;
        if (longint'(brk) + nu > HEAP) return 1'b0;
        up = brk;
        set_size(up, int'(nu));
        brk += int'(nu);
        dummy = put_back(up);
        return 1'b1;
    endfunction

    // First-fit walk from the rover; returns the header unit granted
    function automatic int unsigned first_fit(longint unsigned nbytes, output bit ok);
        longint unsigned nu;
        int unsigned prev;
        int unsigned p;
        int unsigned psz;
        int unsigned steps;
        nu = (nbytes + UNIT_B - 1) / UNIT_B + 1;
        prev = rover;
        p = link_of(prev);
        steps = 0;
        ok = 1'b0;
        while (steps < 3 * HEAP + 8)
        begin
            psz = size_of(p);
            steps++;
            if (psz >= nu)
            begin
                if (psz == nu)
                    set_link(prev, link_of(p));
                else
                begin
                    psz -= int'(nu);
                    set_size(p, psz);
                    p += psz;
                    set_size(p, int'(nu));
                end
                rover = prev;
                ok = 1'b1;
                return p;
            end
            if (p == rover)
            begin
                if (!extend_arena(nu)) return 0;
                p = rover;
            end
            prev = p;
            p = link_of(p);
        end
        return 0;
    endfunction

    // Advance the shadow state by one request and return its expected result
    function automatic rsp_t predict_result(req_t r);
        rsp_t e;
        bit ok;
        int unsigned hdr;
        e.status = ST_OK;
        e.block_unit = '0;
        if (r.action == ACT_ALLOC)
        begin
            n_alloc++;
            hdr = first_fit(64'(r.item_count) * 64'(r.item_bytes), ok);
            if (ok)
            begin
                e.block_unit = 12'(hdr + 1);
                if (hdr < HEAP - 1) live_blocks.push_back(hdr + 1);
            end
            else
            begin
                e.status = ST_OOM;
                n_oom++;
            end
        end
        else
        begin
            n_free++;
            if (r.release_unit >= 2 && r.release_unit - 1 < brk)
                void'(put_back(r.release_unit - 1));
        end
        return e;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) return $urandom_range(1, 2);
        if (r < 18) return $urandom_range(3, 6);
        return $urandom_range(20, 60);
    endfunction

    // Drive one request, hold it until accepted, then record its expectation
    task automatic send_req(input req_t r, input bit typed, input rsp_t typed_rsp);
        rsp_t e;
        int g;
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        e = predict_result(r);
        if (typed) e = typed_rsp;
        pending_rsp.push_back(e);
        g = (quiet_req || $urandom_range(0, 1) == 0) ? 0 : gap_len();
        if (g > 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Hold off until every result is back, then let the block settle
    task automatic drain();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_grow(input logic [CFG_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        grow_min = v;
        n_cfg++;
    endtask

    function automatic req_t random_req();
        req_t r;
        int sel;
        int idx;
        r.action = ACT_ALLOC;
        r.item_count = 16'($urandom);
        r.item_bytes = 16'($urandom);
        r.release_unit = 12'($urandom);
        sel = $urandom_range(0, 99);
        if (live_blocks.size() > 60) sel = 0;
        if (live_blocks.size() != 0 && sel < 45)
        begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            r.action = ACT_FREE;
            r.release_unit = 12'(live_blocks[idx]);
            live_blocks.delete(idx);
        end
        else if (sel < 50)
        begin
            // ignored frees: sentinel, zero, or past the break pointer
            r.action = ACT_FREE;
            case ($urandom_range(0, 2))
                0: r.release_unit = 12'd0;
                1: r.release_unit = 12'd1;
                default: r.release_unit = (brk + 1 < HEAP) ?
                    12'($urandom_range(brk + 1, HEAP - 1)) : 12'd1;
            endcase
        end
        else if (sel < 80)
        begin
            r.item_count = 16'($urandom_range(1, 3));
            r.item_bytes = 16'($urandom_range(0, 255));
        end
        else if (sel < 92)
        begin
            r.item_count = 16'd1;
            r.item_bytes = 16'($urandom_range(0, 2048));
        end
        else if (sel < 95)
            r.item_count = 16'd0;
        return r;
    endfunction

    // Check results in order against the oldest expectation
    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            n_rsp++;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result status=%0d unit=%0d", rsp.status,
                             rsp.block_unit);
            end
            else
            begin
                e = pending_rsp.pop_front();
                if (rsp.status !== e.status || rsp.block_unit !== e.block_unit)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status=%0d unit=%0d, got status=%0d unit=%0d",
                                 e.status, e.block_unit, rsp.status, rsp.block_unit);
                end
            end
        end
    end

    // Randomly stall the result side
    always @(posedge clk)
    begin
        bit s;
        if (stall_hold != 0)
            stall_hold <= stall_hold - 1;
        else
        begin
            s = !quiet_rsp && $urandom_range(0, 3) == 0;
            rsp_stall <= s;
            stall_hold <= s ? gap_len() : $urandom_range(0, 6);
        end
    end

    // Watchdog on cycles with no progress
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        dir_row_t rows[$];
        dir_row_t d;
        req_t r;
        rsp_t t;
        int unsigned grow_vals[5];
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        stall_hold = 0;
        quiet_rsp = 1'b0;
        quiet_req = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        n_alloc = 0; n_oom = 0; n_free = 0; n_cfg = 0; n_rsp = 0;
        foreach (hdr_next[i])
        begin
            hdr_next[i] = 0;
            hdr_size[i] = 0;
        end
        rover = 0;
        brk = 1;
        grow_min = GROW_RESET;

        // Directed rows: act, count, bytes, rel, pick, typed, status, unit
        rows = '{
            '{ACT_ALLOC, 16'd1, 16'd16, 12'd0, PICK_NONE, 1'b1, ST_OK, 12'd1024},
            '{ACT_ALLOC, 16'hFFFF, 16'hFFFF, 12'hFFF, PICK_NONE, 1'b1, ST_OOM, 12'd0},
            '{ACT_ALLOC, 16'd0, 16'd5, 12'd0, PICK_NONE, 1'b0, ST_OK, 12'd0},
            '{ACT_ALLOC, 16'd1, 16'd0, 12'd0, PICK_NONE, 1'b0, ST_OK, 12'd0},
            '{ACT_ALLOC, 16'd3, 16'd100, 12'd0, PICK_NONE, 1'b0, ST_OK, 12'd0},
            '{ACT_FREE, 16'hFFFF, 16'hFFFF, 12'd0, PICK_NEWEST, 1'b1, ST_OK, 12'd0},
            '{ACT_FREE, 16'd0, 16'd0, 12'd1, PICK_NONE, 1'b1, ST_OK, 12'd0},
            '{ACT_FREE, 16'd0, 16'd0, 12'd4095, PICK_NONE, 1'b1, ST_OK, 12'd0},
            '{ACT_FREE, 16'd0, 16'd0, 12'd0, PICK_NONE, 1'b1, ST_OK, 12'd0},
            '{ACT_ALLOC, 16'd1, 16'd16000, 12'd0, PICK_NONE, 1'b0, ST_OK, 12'd0},
            '{ACT_ALLOC, 16'd1, 16'hFFFF, 12'd0, PICK_NONE, 1'b1, ST_OOM, 12'd0},
            '{ACT_ALLOC, 16'd256, 16'd256, 12'd0, PICK_NONE, 1'b1, ST_OOM, 12'd0},
            '{ACT_FREE, 16'd0, 16'd0, 12'd0, PICK_NEWEST, 1'b1, ST_OK, 12'd0},
            '{ACT_FREE, 16'd0, 16'd0, 12'd0, PICK_OLDEST, 1'b1, ST_OK, 12'd0},
            '{ACT_ALLOC, 16'd2, 16'd8, 12'd0, PICK_NONE, 1'b0, ST_OK, 12'd0},
            '{ACT_ALLOC, 16'd1, 16'd40000, 12'd0, PICK_NONE, 1'b0, ST_OK, 12'd0},
            '{ACT_ALLOC, 16'd4, 16'd4000, 12'd0, PICK_NONE, 1'b0, ST_OK, 12'd0},
            '{ACT_FREE, 16'd0, 16'd0, 12'd0, PICK_OLDEST, 1'b1, ST_OK, 12'd0},
            '{ACT_FREE, 16'd0, 16'd0, 12'd0, PICK_NEWEST, 1'b1, ST_OK, 12'd0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (rows[i])
        begin
            d = rows[i];
            r.action = d.action;
            r.item_count = d.count;
            r.item_bytes = d.bytes;
            r.release_unit = d.rel;
            if (d.pick == PICK_NEWEST && live_blocks.size() != 0)
                r.release_unit = 12'(live_blocks.pop_back());
            else if (d.pick == PICK_OLDEST && live_blocks.size() != 0)
                r.release_unit = 12'(live_blocks.pop_front());
            t.status = d.st;
            t.block_unit = d.unit;
            send_req(r, d.typed, t);
        end

        // Random phases, one growth setting each
        grow_vals[0] = 1;
        grow_vals[1] = 4095;
        grow_vals[2] = 4096;
        grow_vals[3] = $urandom_range(1, 4096);
        grow_vals[4] = 1024;
        t = '0;
        foreach (grow_vals[ph])
        begin
            write_grow(CFG_W'(grow_vals[ph]));
            quiet_req = (ph == 2);
            quiet_rsp = (ph == 2);
            repeat (PHASE_ITEMS)
                send_req(random_req(), 1'b0, t);
        end

        drain();
        $display("Ran %0d allocates (%0d out of memory) and %0d frees, %0d results checked,",
                 n_alloc, n_oom, n_free, n_rsp);
        $display("over %0d growth settings; final break pointer %0d.", n_cfg, brk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
src/ffa_pkg.sv
src/ffa_div.sv
src/ffa_dpath.sv
src/ffa_ctrl.sv
src/first_fit_free_list_allocator.sv
dv/tb_first_fit_free_list_allocator.sv
